// File: design/qte_pkg.sv
// Shared widths, constants and the arctangent table of the quaternion to Euler converter.
`default_nettype none
package qte_pkg;

  // Datapath width of the CORDIC x and y lanes (guard bits included).
  localparam int DW = 58;
  // Width of the quadratic sums before scaling.
  localparam int SW = 35;
  // Width of one component product.
  localparam int PW = 32;
  // Width of the angle accumulator, 1/65536 hundredth of a degree.
  localparam int ZW = 33;
  // Guard bits added in front of the CORDIC.
  localparam int GUARD_BITS = 20;
  // Number of CORDIC iterations, 8 to 24.
  localparam int CORDIC_STAGES = 16;
  // CORDIC gain in Q20.
  localparam logic signed [22:0] KQ = 23'sd1726753;
  // Half turn in accumulator units.
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd18000 * 64'sd65536);
  localparam int YAW_LIM = 18000;
  localparam int PITCH_LIM = 9000;
  localparam logic [7:0] REPORT_ID_RESET = 8'h28;

  typedef struct packed {
    logic signed [DW-1:0] aux;
    logic signed [ZW-1:0] ang0;
    logic signed [ZW-1:0] ang1;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      0: r = 33'sd294912000;
      1: r = 33'sd174096719;
      2: r = 33'sd91987925;
      3: r = 33'sd46694507;
      4: r = 33'sd23437865;
      5: r = 33'sd11730358;
      6: r = 33'sd5866610;
      7: r = 33'sd2933484;
      8: r = 33'sd1466765;
      9: r = 33'sd733385;
      10: r = 33'sd366693;
      11: r = 33'sd183346;
      12: r = 33'sd91673;
      13: r = 33'sd45837;
      14: r = 33'sd22918;
      15: r = 33'sd11459;
      16: r = 33'sd5730;
      17: r = 33'sd2865;
      18: r = 33'sd1432;
      19: r = 33'sd716;
      20: r = 33'sd358;
      21: r = 33'sd179;
      22: r = 33'sd90;
      23: r = 33'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/qte_front.sv
// Front end: component products, quadratic sums, gain-scaled pitch term and guard-bit scaling.
`default_nettype none
module qte_front
  import qte_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [15:0]   qr_i,
  input  wire logic signed [15:0]   qi_i,
  input  wire logic signed [15:0]   qj_i,
  input  wire logic signed [15:0]   qk_i,
  output logic                      valid_o,
  output logic signed [DW-1:0]      yy_o,
  output logic signed [DW-1:0]      yx_o,
  output logic signed [DW-1:0]      ry_o,
  output logic signed [DW-1:0]      rx_o,
  output logic signed [DW-1:0]      skq_o
);

  logic a_v_q, b_v_q, c_v_q;
  logic signed [PW-1:0] pi2_q, pj2_q, pk2_q, pr2_q, pij_q, pkr_q, pjk_q, pir_q, pik_q, pjr_q;
  logic signed [SW-1:0] yy_q, yx_q, ry_q, rx_q, s_q;
  logic signed [SW-1:0] yy_d, yx_d, ry_d, rx_d, s_d;
  logic signed [DW-1:0] yyc_q, yxc_q, ryc_q, rxc_q, skq_q;
  logic signed [SW+22:0] skq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  // Stage A: the ten products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pi2_q <= qi_i * qi_i;
      pj2_q <= qj_i * qj_i;
      pk2_q <= qk_i * qk_i;
      pr2_q <= qr_i * qr_i;
      pij_q <= qi_i * qj_i;
      pkr_q <= qk_i * qr_i;
      pjk_q <= qj_i * qk_i;
      pir_q <= qi_i * qr_i;
      pik_q <= qi_i * qk_i;
      pjr_q <= qj_i * qr_i;
    end
  end

  // Stage B: the atan2 arguments and the pitch numerator.
  always_comb begin
    yy_d = (SW'(pij_q) + SW'(pkr_q)) <<< 1;
    yx_d = SW'(pi2_q) - SW'(pj2_q) - SW'(pk2_q) + SW'(pr2_q);
    ry_d = (SW'(pjk_q) + SW'(pir_q)) <<< 1;
    rx_d = SW'(pk2_q) + SW'(pr2_q) - SW'(pi2_q) - SW'(pj2_q);
    s_d  = (SW'(pjr_q) - SW'(pik_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yy_q <= yy_d;
      yx_q <= yx_d;
      ry_q <= ry_d;
      rx_q <= rx_d;
      s_q  <= s_d;
    end
  end

  // Stage C: the pitch numerator picks up the CORDIC gain, the rest gets guard bits.
  assign skq_d = s_q * KQ;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yyc_q <= DW'(yy_q) <<< GUARD_BITS;
      yxc_q <= DW'(yx_q) <<< GUARD_BITS;
      ryc_q <= DW'(ry_q) <<< GUARD_BITS;
      rxc_q <= DW'(rx_q) <<< GUARD_BITS;
      skq_q <= DW'(skq_d);
    end
  end

  assign valid_o = c_v_q;
  assign yy_o    = yyc_q;
  assign yx_o    = yxc_q;
  assign ry_o    = ryc_q;
  assign rx_o    = rxc_q;
  assign skq_o   = skq_q;

endmodule
`default_nettype wire

// File: design/qte_cordic.sv
// Pipelined vectoring CORDIC: half-plane fold, one register per iteration, side data carried along.
`default_nettype none
module qte_cordic
  import qte_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [DW-1:0] x_i,
  input  wire logic signed [DW-1:0] y_i,
  input  wire side_t                side_i,
  output logic                      valid_o,
  output logic signed [DW-1:0]      mag_o,
  output logic signed [ZW-1:0]      ang_o,
  output side_t                     side_o
);

  localparam int N = CORDIC_STAGES;

  logic                 v_q    [0:N];
  logic                 zero_q [0:N];
  logic signed [DW-1:0] x_q    [0:N];
  logic signed [DW-1:0] y_q    [0:N];
  logic signed [ZW-1:0] z_q    [0:N];
  side_t                side_q [0:N];

  // Fold the left half plane onto the right one before the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      side_q[0] <= side_i;
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [DW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_tab(i);
        end
      end
    end
  end

  // A zero vector gives angle and magnitude zero.
  assign valid_o = v_q[N];
  assign mag_o   = zero_q[N] ? '0 : x_q[N];
  assign ang_o   = zero_q[N] ? '0 : z_q[N];
  assign side_o  = side_q[N];

endmodule
`default_nettype wire

// File: design/quaternion_to_euler_angles_core.sv
// Top level of the quaternion to Z-Y-X Euler angle converter.
`default_nettype none
// Converts rotation vector reports (report identifier on tuser plus four signed Q14 quaternion
// components on tdata) into yaw, pitch and roll in hundredths of a degree. Reports whose
// identifier differs from the configured one (0x28 after reset) are dropped and give no output
// transfer. The block takes one transfer per clock cycle when the output side keeps up.
// The two CORDIC pipelines run in series: yaw and roll run side by side, and pitch is the
// arctangent of the gain-scaled numerator against the roll magnitude, so it can only start
// when roll is done. One enable moves the whole pipeline; it stalls only while the output
// register holds a transfer that is not taken, so nothing is lost or repeated. The identifier
// register may be written only while the block is idle.
module quaternion_to_euler_angles_core
  import qte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,        // accepted_report_id
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,       // quat_real, quat_i, quat_j, quat_k
  input  wire logic [7:0]  s_axis_tuser,       // report_id
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata        // yaw_angle, pitch_angle, roll_angle, zero pad
);

  logic [7:0] report_id_q;
  logic       en;
  logic       in_ok;

  logic                 fr_v;
  logic signed [DW-1:0] yy, yx, ry, rx, skq;
  side_t                yaw_side_in, roll_side_in, pitch_side_in;
  side_t                yaw_side, roll_side, pitch_side;
  logic                 yaw_v, roll_v, pitch_v;
  logic signed [DW-1:0] yaw_mag, roll_mag, pitch_mag;
  logic signed [ZW-1:0] yaw_ang, roll_ang, pitch_ang;

  logic                 out_v_q;
  logic signed [15:0]   yaw_q, roll_q;
  logic signed [14:0]   pitch_q;
  logic signed [15:0]   yaw_d, roll_d;
  logic signed [14:0]   pitch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q <= REPORT_ID_RESET;
    end else if (cfg_we_i) begin
      report_id_q <= cfg_wdata_i;
    end
  end

  // The pipeline moves unless a finished result is waiting on the output side.
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_ok         = s_axis_tvalid && (s_axis_tuser == report_id_q);

  qte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_ok),
    .qr_i    (s_axis_tdata[15:0]),
    .qi_i    (s_axis_tdata[31:16]),
    .qj_i    (s_axis_tdata[47:32]),
    .qk_i    (s_axis_tdata[63:48]),
    .valid_o (fr_v),
    .yy_o    (yy),
    .yx_o    (yx),
    .ry_o    (ry),
    .rx_o    (rx),
    .skq_o   (skq)
  );

  // Yaw and roll share timing; the roll lane carries the pitch numerator along.
  assign yaw_side_in  = '{aux: '0, ang0: '0, ang1: '0};
  assign roll_side_in = '{aux: skq, ang0: '0, ang1: '0};

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .x_i     (yx),
    .y_i     (yy),
    .side_i  (yaw_side_in),
    .valid_o (yaw_v),
    .mag_o   (yaw_mag),
    .ang_o   (yaw_ang),
    .side_o  (yaw_side)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .x_i     (rx),
    .y_i     (ry),
    .side_i  (roll_side_in),
    .valid_o (roll_v),
    .mag_o   (roll_mag),
    .ang_o   (roll_ang),
    .side_o  (roll_side)
  );

  // Pitch is asin written as atan2 of the numerator against the roll magnitude.
  assign pitch_side_in = '{aux: '0, ang0: yaw_ang, ang1: roll_ang};

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (roll_v),
    .x_i     (roll_mag),
    .y_i     (roll_side.aux),
    .side_i  (pitch_side_in),
    .valid_o (pitch_v),
    .mag_o   (pitch_mag),
    .ang_o   (pitch_ang),
    .side_o  (pitch_side)
  );

  // Round to hundredths of a degree and clip each angle to its range.
  function automatic logic signed [17:0] round_clip(input logic signed [ZW-1:0] z,
                                                    input int lim);
    logic signed [ZW:0]   t;
    logic signed [17:0]   a;
    logic signed [17:0]   l;
    t = ZW'(z) + (ZW+1)'(32768);
    a = 18'(t >>> 16);
    l = 18'(lim);
    if (a > l) begin
      a = l;
    end else if (a < -l) begin
      a = -l;
    end
    return a;
  endfunction

  always_comb begin
    yaw_d   = 16'(round_clip(pitch_side.ang0, YAW_LIM));
    roll_d  = 16'(round_clip(pitch_side.ang1, YAW_LIM));
    pitch_d = 15'(round_clip(pitch_ang, PITCH_LIM));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= pitch_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
      roll_q  <= roll_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, roll_q, pitch_q, yaw_q};

  // The parallel yaw and roll lanes must stay in step.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_v == roll_v)
    else $error("yaw and roll lanes out of step");

  // A report with a foreign identifier never enters the pipeline.
  a_drop_foreign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s_axis_tvalid && (s_axis_tuser != report_id_q)) |-> !in_ok)
    else $error("foreign report entered the pipeline");

  // Yaw and pitch leave within their ranges; the yaw, roll and pitch magnitudes are never negative.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (pitch_q <= 15'sd9000) && (pitch_q >= -15'sd9000)
                && (yaw_q <= 16'sd18000) && (yaw_q >= -16'sd18000)
                && (roll_mag >= 0) && (yaw_mag >= 0) && (pitch_mag >= 0))
    else $error("result out of range");

endmodule
`default_nettype wire
